/* src/spsl_pkg.sv */
// ----------------------------------------------------------------------------
// spsl_pkg
// Types and constants shared by the servo pulse slew limiter modules.
// ----------------------------------------------------------------------------
package spsl_pkg;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_NEUTRAL_WIDTH  = 2'd0,
        CFG_ANGLE_GAIN     = 2'd1,
        CFG_MAX_STEP       = 2'd2,
        CFG_DIRECTION_MASK = 2'd3
    } t_cfg_idx;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [15:0] NEUTRAL_RESET  = 16'd30000;
    localparam logic [7:0]  GAIN_RESET     = 8'd142;
    localparam logic [15:0] MAX_STEP_RESET = 16'd1000;
    localparam logic [7:0]  MASK_RESET     = 8'd0;
    localparam logic [15:0] WIDTH_RESET    = 16'd30000;

    // divide by the 50 Hz tick rate: floor(p / 50) == (p * 83887) >> 22 for p < 2^16
    localparam logic [32:0] RECIP_50    = 33'd83887;
    localparam int          RECIP_SHIFT = 22;

    typedef struct packed {
        logic [2:0]        channel;
        logic signed [7:0] target_angle;
        logic [7:0]        move_speed;
        logic signed [7:0] trim_offset;
    } t_in_word;

    typedef struct packed {
        logic [15:0] pulse_width;
        logic        locked;
        logic [7:0]  lock_flags;
    } t_out_word;

    typedef struct packed {
        logic [15:0] neutral_width;
        logic [7:0]  angle_gain;
        logic [15:0] max_step;
        logic [7:0]  direction_mask;
    } t_cfg;

    // after the multiply stage
    typedef struct packed {
        logic [2:0]         channel;
        logic signed [16:0] term;
        logic [15:0]        speed_prod;
    } t_prod;

    // target and step limit of one update
    typedef struct packed {
        logic [2:0]  channel;
        logic [15:0] target;
        logic [15:0] step;
    } t_target;

endpackage

/* src/servo_pulse_slew_limiter.sv */
// ----------------------------------------------------------------------------
// servo_pulse_slew_limiter
// Moves each servo channel's pulse width toward its target by a speed-limited
// step and reports the new width with the channel lock flags.
// ----------------------------------------------------------------------------
//   channel   dir  handshake                 word
//   in        in   i_in_valid / o_in_stall   i_in_word  (t_in_word)
//   out       out  o_out_valid / i_out_stall o_out_word (t_out_word)
//   cfg       in   i_cfg_we                  i_cfg_index, i_cfg_data
//
// one word per cycle sustained while the output does not stall; words pass
// through the input register, product stage, target stage and result register.
// the width update closes in the slew stage, so same-channel words go back to back.
// synchronous reset restores register defaults, widths to 30000, locks clear.
// an output stall backs up through the stages; a stage keeps taking words
// while the one after it has room.
module servo_pulse_slew_limiter
    import spsl_pkg::*;
#(
    parameter int CHANNELS = 8
)
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_word              i_in_word,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_word             o_out_word,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg     r_cfg;
    logic     r_in_valid;
    t_in_word r_in;
    logic     in_ready;
    logic     tgt_stall;
    logic     tgt_valid;
    t_target  tgt;
    logic     slew_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.neutral_width  <= NEUTRAL_RESET;
            r_cfg.angle_gain     <= GAIN_RESET;
            r_cfg.max_step       <= MAX_STEP_RESET;
            r_cfg.direction_mask <= MASK_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_NEUTRAL_WIDTH:  r_cfg.neutral_width  <= i_cfg_data;
                CFG_ANGLE_GAIN:     r_cfg.angle_gain     <= i_cfg_data[7:0];
                CFG_MAX_STEP:       r_cfg.max_step       <= i_cfg_data;
                CFG_DIRECTION_MASK: r_cfg.direction_mask <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // input register
    assign in_ready   = !r_in_valid || !tgt_stall;
    assign o_in_stall = !in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_in_valid) begin
            r_in <= i_in_word;
        end
    end

    spsl_target u_target (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (r_in_valid),
        .i_word  (r_in),
        .o_stall (tgt_stall),
        .o_valid (tgt_valid),
        .o_tgt   (tgt),
        .i_stall (slew_stall)
    );

    spsl_slew #(
        .CHANNELS (CHANNELS)
    ) u_slew (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (tgt_valid),
        .i_tgt       (tgt),
        .o_stall     (slew_stall),
        .o_valid     (o_out_valid),
        .o_word      (o_out_word),
        .i_out_stall (i_out_stall)
    );

endmodule

/* src/spsl_target.sv */
// ----------------------------------------------------------------------------
// spsl_target
// Two pipeline stages: gain products, then clamped target width and step limit.
// ----------------------------------------------------------------------------
module spsl_target
    import spsl_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg     i_cfg,
    input  logic     i_valid,
    input  t_in_word i_word,
    output logic     o_stall,
    output logic     o_valid,
    output t_target  o_tgt,
    input  logic     i_stall
);

    logic    r_p_valid;
    t_prod   r_p;
    t_prod   n_p;
    logic    r_t_valid;
    t_target r_t;
    t_target n_t;

    logic ready_t;
    logic ready_p;

    logic signed [8:0]  sum;
    logic signed [17:0] term_full;

    logic               neg;
    logic signed [16:0] term_dir;
    logic signed [17:0] tgt_wide;
    logic [32:0]        q_prod;
    logic [15:0]        q;

    assign ready_t = !r_t_valid || !i_stall;
    assign ready_p = !r_p_valid || ready_t;
    assign o_stall = !ready_p;
    assign o_valid = r_t_valid;
    assign o_tgt   = r_t;

    // stage 1: gain times angle sum, gain times speed
    always_comb begin
        sum       = {i_word.target_angle[7], i_word.target_angle}
                  + {i_word.trim_offset[7], i_word.trim_offset};
        term_full = $signed({1'b0, i_cfg.angle_gain}) * sum;
        n_p.channel    = i_word.channel;
        n_p.term       = term_full[16:0];
        n_p.speed_prod = i_cfg.angle_gain * i_word.move_speed;
    end

    // stage 2: direction, neutral offset, saturation, step limit
    always_comb begin
        neg      = i_cfg.direction_mask[r_p.channel];
        term_dir = neg ? -r_p.term : r_p.term;
        tgt_wide = $signed({2'b00, i_cfg.neutral_width}) + {term_dir[16], term_dir};
        n_t.channel = r_p.channel;
        if (tgt_wide[17]) begin
            n_t.target = '0;
        end else if (tgt_wide[16]) begin
            n_t.target = '1;
        end else begin
            n_t.target = tgt_wide[15:0];
        end
        q_prod = {17'd0, r_p.speed_prod} * RECIP_50;
        q      = {5'd0, q_prod[RECIP_SHIFT +: 11]};
        n_t.step = (q > i_cfg.max_step) ? i_cfg.max_step : q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_t_valid <= 1'b0;
        end else begin
            if (ready_p) begin
                r_p_valid <= i_valid;
            end
            if (ready_t) begin
                r_t_valid <= r_p_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready_p && i_valid) begin
            r_p <= n_p;
        end
        if (ready_t && r_p_valid) begin
            r_t <= n_t;
        end
    end

endmodule

/* src/spsl_slew.sv */
// ----------------------------------------------------------------------------
// spsl_slew
// Per-channel width and lock state, slew step toward target, result register.
// ----------------------------------------------------------------------------
module spsl_slew
    import spsl_pkg::*;
#(
    parameter int CHANNELS = 8
)
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_target   i_tgt,
    output logic      o_stall,
    output logic      o_valid,
    output t_out_word o_word,
    input  logic      i_out_stall
);

    localparam int          CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [3:0]  NCH  = 4'(CHANNELS);

    logic [15:0]         r_width [CHANNELS];
    logic [CHANNELS-1:0] r_lock;
    logic [CHANNELS-1:0] n_lock;
    logic                r_out_valid;
    t_out_word           r_out;
    t_out_word           n_out;

    logic               ready;
    logic               commit;
    logic               ch_ok;
    logic [CH_W-1:0]    idx;
    logic [15:0]        cur;
    logic signed [16:0] diff;
    logic signed [16:0] stp;
    logic [15:0]        nxt;
    logic               lock;

    assign ready   = !r_out_valid || !i_out_stall;
    assign commit  = i_valid && ready;
    assign o_stall = !ready;
    assign o_valid = r_out_valid;
    assign o_word  = r_out;

    always_comb begin
        ch_ok = {1'b0, i_tgt.channel} < NCH;
        idx   = i_tgt.channel[CH_W-1:0];
        cur   = r_width[idx];
        diff  = $signed({1'b0, i_tgt.target}) - $signed({1'b0, cur});
        stp   = $signed({1'b0, i_tgt.step});
        if (diff > stp) begin
            nxt  = cur + i_tgt.step;
            lock = 1'b0;
        end else if (diff < -stp) begin
            nxt  = cur - i_tgt.step;
            lock = 1'b0;
        end else begin
            nxt  = i_tgt.target;
            lock = 1'b1;
        end
        n_lock = r_lock;
        if (ch_ok) begin
            n_lock[idx] = lock;
        end
        n_out.pulse_width = ch_ok ? nxt : 16'd0;
        n_out.locked      = ch_ok && lock;
        n_out.lock_flags  = 8'(n_lock);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_width[c] <= WIDTH_RESET;
            end
            r_lock      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (commit && ch_ok) begin
                r_width[idx] <= nxt;
            end
            if (commit) begin
                r_lock <= n_lock;
            end
            if (ready) begin
                r_out_valid <= i_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_out <= n_out;
        end
    end

endmodule

/* verif/tb_servo_pulse_slew_limiter.sv */
// ----------------------------------------------------------------------------
// tb_servo_pulse_slew_limiter
// Self-checking bench for the servo pulse slew limiter: a queue-fed driver
// pushes channel updates under random gaps and output stalls, and the monitor
// checks every result word against an in-bench model of the per-channel width
// and lock state, across several register settings including the extremes.
// ----------------------------------------------------------------------------
module tb_servo_pulse_slew_limiter;
    import spsl_pkg::*;

    localparam int NUM_CH       = 8;
    localparam int PHASES       = 8;
    localparam int RANDOM_WORDS = 100;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PIPE_DEPTH   = 4;
    localparam int MAX_REPORTS  = 40;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    t_in_word              i_in_word;
    logic                  o_out_valid;
    logic                  i_out_stall;
    t_out_word             o_out_word;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    servo_pulse_slew_limiter #(.CHANNELS(NUM_CH)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // model state
    t_cfg        cfg_model;
    logic [15:0] width_model [NUM_CH];
    logic [7:0]  lock_model;

    t_in_word    update_q [$];
    t_out_word   width_exp_q [$];

    int queued_cnt;
    int accepted_cnt;
    int result_cnt;
    int lock_cnt;
    int error_cnt;
    int cycle_cnt;
    bit word_taken;
    bit quiet_phase;
    int in_gap_left;
    int out_stall_left;
    t_out_word want;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // mostly short gaps, a few long ones; none in quiet phases
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_phase || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // advance one channel toward its target, return the result word
    function automatic t_out_word slew_update(t_in_word w);
        t_out_word res;
        int term;
        int target;
        int step;
        int cur;
        int diff;
        int nxt;
        bit lock;
        term = int'(cfg_model.angle_gain)
             * (int'($signed(w.trim_offset)) + int'($signed(w.target_angle)));
        if (cfg_model.direction_mask[w.channel])
            term = -term;
        target = int'(cfg_model.neutral_width) + term;
        if (target < 0)
            target = 0;
        if (target > 65535)
            target = 65535;
        step = (int'(cfg_model.angle_gain) * int'(w.move_speed)) / 50;
        if (step > int'(cfg_model.max_step))
            step = int'(cfg_model.max_step);
        cur  = int'(width_model[w.channel]);
        diff = target - cur;
        if (diff > step) begin
            nxt  = cur + step;
            lock = 1'b0;
        end else if (diff < -step) begin
            nxt  = cur - step;
            lock = 1'b0;
        end else begin
            nxt  = target;
            lock = 1'b1;
        end
        width_model[w.channel] = nxt[15:0];
        lock_model[w.channel]  = lock;
        res.pulse_width = nxt[15:0];
        res.locked      = lock;
        res.lock_flags  = lock_model;
        return res;
    endfunction

    task automatic push_update(input logic [2:0] ch, input logic [7:0] ang,
                               input logic [7:0] spd, input logic [7:0] trim);
        t_in_word w;
        w.channel      = ch;
        w.target_angle = ang;
        w.move_speed   = spd;
        w.trim_offset  = trim;
        update_q.push_back(w);
        queued_cnt++;
    endtask

    // mostly repeated moves toward one target so channels get to lock,
    // the rest fully random words
    task automatic fill_random(input int count);
        int done;
        int reps;
        t_in_word w;
        done = 0;
        while (done < count) begin
            if ($urandom_range(0, 9) < 7) begin
                w.channel      = 3'($urandom_range(0, NUM_CH - 1));
                w.target_angle = 8'($urandom);
                w.trim_offset  = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                            : 8'($urandom_range(0, 15) - 8);
                w.move_speed   = 8'($urandom_range(20, 255));
                reps = $urandom_range(2, 10);
                repeat (reps) begin
                    if ($urandom_range(0, 4) == 0)
                        w.move_speed = 8'($urandom);
                    push_update(w.channel, w.target_angle, w.move_speed, w.trim_offset);
                    done++;
                end
            end else begin
                w = t_in_word'($urandom);
                push_update(w.channel, w.target_angle, w.move_speed, w.trim_offset);
                done++;
            end
        end
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [15:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        case (idx)
            CFG_NEUTRAL_WIDTH:  cfg_model.neutral_width  = data;
            CFG_ANGLE_GAIN:     cfg_model.angle_gain     = data[7:0];
            CFG_MAX_STEP:       cfg_model.max_step       = data;
            CFG_DIRECTION_MASK: cfg_model.direction_mask = data[7:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        while (!(accepted_cnt == queued_cnt && width_exp_q.size() == 0))
            @(negedge i_clk);
    endtask

    // driver: a stalled word holds until taken
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !word_taken) begin
            end else if (in_gap_left > 0) begin
                i_in_valid  <= 1'b0;
                in_gap_left--;
            end else if (update_q.size() > 0) begin
                i_in_word   <= update_q.pop_front();
                i_in_valid  <= 1'b1;
                in_gap_left = pick_gap();
            end else begin
                i_in_valid  <= 1'b0;
            end
            word_taken = 1'b0;

            if (out_stall_left > 0) begin
                i_out_stall <= 1'b1;
                out_stall_left--;
            end else begin
                i_out_stall <= 1'b0;
                out_stall_left = pick_gap();
            end
        end
    end

    // monitor: predict on acceptance, check on result
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("%0t timeout with %0d results outstanding", $time, width_exp_q.size());
            $display("tb: failure");
            $finish;
        end
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                word_taken = 1'b1;
                width_exp_q.push_back(slew_update(i_in_word));
                accepted_cnt++;
            end
            if (o_out_valid && !i_out_stall) begin
                result_cnt++;
                if (width_exp_q.size() == 0) begin
                    error_cnt++;
                    if (error_cnt <= MAX_REPORTS)
                        $display("%0t unexpected result word %h", $time, o_out_word);
                end else begin
                    want = width_exp_q.pop_front();
                    if (want.locked)
                        lock_cnt++;
                    if (o_out_word.pulse_width !== want.pulse_width) begin
                        error_cnt++;
                        if (error_cnt <= MAX_REPORTS)
                            $display("%0t pulse_width expected %0d actual %0d", $time,
                                     want.pulse_width, o_out_word.pulse_width);
                    end
                    if (o_out_word.locked !== want.locked) begin
                        error_cnt++;
                        if (error_cnt <= MAX_REPORTS)
                            $display("%0t locked expected %0b actual %0b", $time,
                                     want.locked, o_out_word.locked);
                    end
                    if (o_out_word.lock_flags !== want.lock_flags) begin
                        error_cnt++;
                        if (error_cnt <= MAX_REPORTS)
                            $display("%0t lock_flags expected %h actual %h", $time,
                                     want.lock_flags, o_out_word.lock_flags);
                    end
                end
            end
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_in_word      = '0;
        i_out_stall    = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        queued_cnt     = 0;
        accepted_cnt   = 0;
        result_cnt     = 0;
        lock_cnt       = 0;
        error_cnt      = 0;
        cycle_cnt      = 0;
        word_taken     = 1'b0;
        quiet_phase    = 1'b0;
        in_gap_left    = 0;
        out_stall_left = 0;
        cfg_model.neutral_width  = NEUTRAL_RESET;
        cfg_model.angle_gain     = GAIN_RESET;
        cfg_model.max_step       = MAX_STEP_RESET;
        cfg_model.direction_mask = MASK_RESET;
        for (int c = 0; c < NUM_CH; c++)
            width_model[c] = WIDTH_RESET;
        lock_model = '0;

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed words at reset settings
        push_update(3'd2, 8'sd0, 8'd0, 8'sd0);        // zero step, already on target
        push_update(3'd3, 8'sd10, 8'd0, 8'sd0);       // zero step, off target
        push_update(3'd0, 8'sd127, 8'd255, 8'sd127);  // target clips high
        push_update(3'd0, 8'sd127, 8'd255, 8'sd127);
        push_update(3'd1, -8'sd128, 8'd255, -8'sd128); // target clips low
        push_update(3'd1, -8'sd128, 8'd255, -8'sd128);
        push_update(3'd4, 8'sd5, 8'd10, -8'sd5);      // trim cancels angle
        push_update(3'd5, 8'sd1, 8'd255, 8'sd0);
        push_update(3'd6, -8'sd1, 8'd255, 8'sd0);
        push_update(3'd7, 8'sd3, 8'd1, 8'sd0);
        push_update(3'd7, 8'sd3, 8'd255, 8'sd0);
        push_update(3'd0, 8'sd0, 8'd255, -8'sd128);
        push_update(3'd0, 8'sd0, 8'd255, -8'sd128);
        push_update(3'd3, -8'sd128, 8'd128, 8'sd127);
        push_update(3'd5, 8'sd64, 8'd100, 8'sd32);
        push_update(3'd6, -8'sd64, 8'd200, 8'sd32);

        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph > 0) begin
                wait_drained();
                repeat (PIPE_DEPTH) @(negedge i_clk);
                quiet_phase = (ph % 3 == 2);
                case (ph)
                    1: begin
                        write_reg(CFG_NEUTRAL_WIDTH, 16'd0);
                        write_reg(CFG_ANGLE_GAIN, 16'd255);
                        write_reg(CFG_MAX_STEP, 16'hFFFF);
                        write_reg(CFG_DIRECTION_MASK, 16'h00FF);
                    end
                    2: begin
                        write_reg(CFG_NEUTRAL_WIDTH, 16'hFFFF);
                        write_reg(CFG_MAX_STEP, 16'd0);
                        write_reg(CFG_DIRECTION_MASK, 16'h0055);
                    end
                    3: begin
                        write_reg(CFG_ANGLE_GAIN, 16'd0);
                        write_reg(CFG_MAX_STEP, 16'hFFFF);
                        write_reg(CFG_DIRECTION_MASK, 16'hAAAA);
                    end
                    default: begin
                        write_reg(CFG_NEUTRAL_WIDTH, 16'($urandom));
                        write_reg(CFG_ANGLE_GAIN, 16'($urandom));
                        write_reg(CFG_MAX_STEP, ($urandom_range(0, 3) == 0)
                                                ? 16'($urandom) : 16'($urandom_range(0, 2000)));
                        write_reg(CFG_DIRECTION_MASK, 16'($urandom));
                    end
                endcase
            end
            fill_random(RANDOM_WORDS);
        end

        wait_drained();
        repeat (2 * PIPE_DEPTH) @(posedge i_clk);

        $display("checked %0d result words over %0d register settings, %0d of them locked",
                 result_cnt, PHASES, lock_cnt);
        $display("%0d words sent, %0d mismatches", accepted_cnt, error_cnt);
        if (error_cnt == 0 && width_exp_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

/* files.f */
src/spsl_pkg.sv
src/spsl_target.sv
src/spsl_slew.sv
src/servo_pulse_slew_limiter.sv
verif/tb_servo_pulse_slew_limiter.sv
